// File: hdl/nlsa_pkg.sv
// Shared types and constants for the nearest-light slot allocator.
// Holds the stream item layouts, the position type and the distance helper.
// No dependencies.
`timescale 1ns / 1ps

package nlsa_pkg;

  // Fixed field widths
  localparam int unsigned POS_W  = 24;  // signed Q16.8 position
  localparam int unsigned MAG_W  = 24;  // per-axis distance magnitude
  localparam int unsigned SQ_W   = 48;  // per-axis square
  localparam int unsigned DIST_W = 50;  // squared distance, unsigned Q34.16
  localparam int unsigned ID_W   = 16;  // light id on the ports
  localparam int unsigned SLOT_W = 3;   // slot fields on the ports

  // Request kinds carried in tuser
  localparam logic MODE_ADD     = 1'b0;
  localparam logic MODE_REFRESH = 1'b1;

  typedef struct packed {
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } pos_t;

  // Input item, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0]              pad;
    logic signed [POS_W-1:0] camera_z;
    logic signed [POS_W-1:0] camera_y;
    logic signed [POS_W-1:0] camera_x;
    logic signed [POS_W-1:0] light_z;
    logic signed [POS_W-1:0] light_y;
    logic signed [POS_W-1:0] light_x;
    logic                    light_alive;
    logic                    already_mapped;
    logic [ID_W-1:0]         light_id;
    logic [SLOT_W-1:0]       target_slot;
  } in_item_t;

  // Result item, lowest field in the lowest bits
  typedef struct packed {
    logic [2:0]        pad;
    logic [ID_W-1:0]   evicted_id;
    logic              evicted_valid;
    logic [SLOT_W-1:0] granted_slot;
    logic              assigned;
  } out_item_t;

  // |a - b| of two signed positions; the difference always fits in MAG_W bits
  function automatic logic [MAG_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    return d[POS_W] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

endpackage

// File: hdl/nearest_light_slot_allocator_unit.sv
// Nearest-light shadow-map slot allocator, top level.
// Depends on nlsa_pkg and nlsa_dist.
//
// Usage:
//   Slave stream (s_axis_*) takes one request item: tuser selects add (0) or
//   refresh (1). Master stream (m_axis_*) returns exactly one result item
//   per request. No configuration port.
//   Slot ids and distances live in one synchronous RAM (one read and one
//   write port, registered read); valid marks are flip-flops.
//   Add: all SLOT_COUNT entries are read, one per cycle, to find the first
//   empty slot or else the first farthest one, while nlsa_dist computes the
//   squared distance one axis per cycle. Refresh reads only the target slot.
//   The result is written to the result register after both the slot scan
//   through the RAM read port and the distance unit are done.
//   One item is processed at a time; a new item is taken in the cycle after
//   the previous one has been written to the result register. The table
//   write happens only in the last cycle, after all reads of that item, so a
//   following item always reads updated entries.
//   Reset empties every slot at once; no clearing pass is needed.
//   A stalled receiver holds the result register; the block then finishes
//   the next item and waits with it until the result register is free.
`timescale 1ns / 1ps

module nearest_light_slot_allocator_unit #(
  parameter int SLOT_COUNT    = 8,
  parameter int LIGHT_ID_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: target_slot[2:0], light_id[18:3], already_mapped[19],
  //        light_alive[20], light_x[44:21], light_y[68:45], light_z[92:69],
  //        camera_x[116:93], camera_y[140:117], camera_z[164:141], zero pad
  input  logic [167:0] s_axis_tdata_i,
  // tuser: mode[0] (0 = add, 1 = refresh)
  input  logic         s_axis_tuser_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: assigned[0], granted_slot[3:1], evicted_valid[4],
  //        evicted_id[20:5], zero pad
  output logic [23:0]  m_axis_tdata_o,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W = ((IDX_W > nlsa_pkg::SLOT_W) ? IDX_W : nlsa_pkg::SLOT_W) + 1;
  localparam int ENT_W = LIGHT_ID_BITS + nlsa_pkg::DIST_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  nlsa_pkg::in_item_t  in_item;
  nlsa_pkg::out_item_t res;
  nlsa_pkg::pos_t      light_pos, camera_pos;

  logic [1:0]                  state_q, state_d;
  logic                        accept;
  logic                        commit;

  // Captured request
  logic                        mode_q;
  logic [nlsa_pkg::SLOT_W-1:0] target_q;
  logic [LIGHT_ID_BITS-1:0]    id_q;
  logic                        mapped_q;
  logic                        alive_q;
  logic [IDX_W-1:0]            tgt_idx;
  logic                        tgt_in_range;

  // Table
  logic [SLOT_COUNT-1:0]       valid_q;
  logic [ENT_W-1:0]            mem_q [SLOT_COUNT];
  logic [ENT_W-1:0]            rd_data_q;
  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic                        rd_vld_q;
  logic [IDX_W-1:0]            rd_idx_q;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [ENT_W-1:0]            wr_data;
  logic [LIGHT_ID_BITS-1:0]    rd_id;
  logic [nlsa_pkg::DIST_W-1:0] rd_dist;

  // Scan
  logic [CNT_W-1:0]            rd_cnt_q;
  logic [CNT_W-1:0]            scan_len;
  logic                        scan_done;
  logic                        found_empty_q;
  logic [IDX_W-1:0]            pick_q;
  logic [LIGHT_ID_BITS-1:0]    best_id_q;
  logic [nlsa_pkg::DIST_W-1:0] best_dist_q;

  // Distance
  logic                        dist_done;
  logic [nlsa_pkg::DIST_W-1:0] req_dist;

  // Decision
  logic                        take;
  logic                        set_valid;
  logic                        clr_valid;

  // Output register
  logic                        out_valid_q;
  nlsa_pkg::out_item_t         out_q;

  assign in_item         = nlsa_pkg::in_item_t'(s_axis_tdata_i);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign light_pos  = '{x: in_item.light_x, y: in_item.light_y, z: in_item.light_z};
  assign camera_pos = '{x: in_item.camera_x, y: in_item.camera_y, z: in_item.camera_z};

  nlsa_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .light_i  (light_pos),
    .camera_i (camera_pos),
    .done_o   (dist_done),
    .dist_o   (req_dist)
  );

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= s_axis_tuser_i;
      target_q <= in_item.target_slot;
      id_q     <= LIGHT_ID_BITS'(in_item.light_id);
      mapped_q <= in_item.already_mapped;
      alive_q  <= in_item.light_alive;
    end
  end

  assign tgt_idx      = IDX_W'(target_q);
  assign tgt_in_range = (CMP_W'(target_q) < CMP_W'(SLOT_COUNT));

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_WORK;
      ST_WORK: if (scan_done && dist_done) state_d = ST_DONE;
      ST_DONE: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Read issue: add scans every slot, refresh reads the target slot
  assign scan_len  = (mode_q == nlsa_pkg::MODE_ADD) ? CNT_W'(SLOT_COUNT) : CNT_W'(1);
  assign rd_en     = (state_q == ST_WORK) && (rd_cnt_q < scan_len);
  assign rd_addr   = (mode_q == nlsa_pkg::MODE_ADD) ? rd_cnt_q[IDX_W-1:0] : tgt_idx;
  assign scan_done = (rd_cnt_q == scan_len) && !rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q      <= '0;
      rd_vld_q      <= 1'b0;
      found_empty_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (accept) begin
        rd_cnt_q      <= '0;
        found_empty_q <= 1'b0;
      end else begin
        if (rd_en) rd_cnt_q <= rd_cnt_q + CNT_W'(1);
        if (rd_vld_q && (mode_q == nlsa_pkg::MODE_ADD) && !found_empty_q
            && !valid_q[rd_idx_q]) begin
          found_empty_q <= 1'b1;
        end
      end
    end
  end

  // Table RAM
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  assign rd_id   = rd_data_q[ENT_W-1 -: LIGHT_ID_BITS];
  assign rd_dist = rd_data_q[nlsa_pkg::DIST_W-1:0];

  // Scan compare: first empty slot wins, else first strictly greatest distance; refresh keeps the read id
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (mode_q == nlsa_pkg::MODE_REFRESH) begin
        best_id_q <= rd_id;
      end else if (!found_empty_q) begin
        if (!valid_q[rd_idx_q]) begin
          pick_q <= rd_idx_q;
        end else if ((rd_idx_q == '0) || (rd_dist > best_dist_q)) begin
          pick_q      <= rd_idx_q;
          best_id_q   <= rd_id;
          best_dist_q <= rd_dist;
        end
      end
    end
  end

  // Final decision and table update
  assign commit = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    res       = '0;
    take      = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = pick_q;
    wr_data   = {id_q, req_dist};
    if (mode_q == nlsa_pkg::MODE_REFRESH) begin
      res.granted_slot = target_q;
      wr_addr          = tgt_idx;
      wr_data          = {best_id_q, req_dist};
      if (tgt_in_range && valid_q[tgt_idx]) begin
        if (!alive_q) begin
          clr_valid         = commit;
          res.evicted_valid = 1'b1;
          res.evicted_id    = nlsa_pkg::ID_W'(best_id_q);
        end else begin
          wr_en = commit;
        end
      end
    end else if (!mapped_q) begin
      priority if (found_empty_q) begin
        take = 1'b1;
      end else if (best_dist_q > req_dist) begin
        take              = 1'b1;
        res.evicted_valid = 1'b1;
        res.evicted_id    = nlsa_pkg::ID_W'(best_id_q);
      end
      if (take) begin
        res.assigned     = 1'b1;
        res.granted_slot = nlsa_pkg::SLOT_W'(pick_q);
        set_valid        = commit;
        wr_en            = commit;
      end
    end
  end

  // Valid marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (set_valid) valid_q[pick_q] <= 1'b1;
      if (clr_valid) valid_q[tgt_idx] <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) out_q <= res;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// File: hdl/nlsa_dist.sv
// Squared light-to-camera distance unit: one shared 24x24 multiplier, one axis
// per cycle, accumulated into a 50-bit sum. Depends on nlsa_pkg.
`timescale 1ns / 1ps

module nlsa_dist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  nlsa_pkg::pos_t              light_i,
  input  nlsa_pkg::pos_t              camera_i,
  output logic                        done_o,
  output logic [nlsa_pkg::DIST_W-1:0] dist_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [1:0]                        step_q;
  logic [nlsa_pkg::MAG_W-1:0]        mag_x_q, mag_y_q, mag_z_q;
  logic [nlsa_pkg::MAG_W-1:0]        mag_sel;
  logic [nlsa_pkg::SQ_W-1:0]         sq;
  logic [nlsa_pkg::SQ_W-1:0]         prod_q;
  logic [nlsa_pkg::DIST_W-1:0]       acc_q;

  // Axis select and the shared multiplier
  always_comb begin
    unique case (step_q)
      2'd0:    mag_sel = mag_x_q;
      2'd1:    mag_sel = mag_y_q;
      default: mag_sel = mag_z_q;
    endcase
    sq = nlsa_pkg::SQ_W'(mag_sel) * nlsa_pkg::SQ_W'(mag_sel);
  end

  // Control: step 0..2 multiply, steps 1..3 accumulate the previous product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else if (busy_q) begin
      if (step_q == 2'd3) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_x_q <= nlsa_pkg::abs_diff(light_i.x, camera_i.x);
      mag_y_q <= nlsa_pkg::abs_diff(light_i.y, camera_i.y);
      mag_z_q <= nlsa_pkg::abs_diff(light_i.z, camera_i.z);
      acc_q   <= '0;
    end else if (busy_q) begin
      prod_q <= sq;
      if (step_q != 2'd0) begin
        acc_q <= acc_q + nlsa_pkg::DIST_W'(prod_q);
      end
    end
  end

  assign done_o = done_q;
  assign dist_o = acc_q;

endmodule

// File: sim/tb_top.sv
// Testbench for the nearest-light slot allocator: directed and random request items
// checked against a slot-table predictor kept in step with every accepted item.
// Depends on nlsa_pkg and nearest_light_slot_allocator_unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOTS   = 8;
  localparam int ID_BITS = 16;
  localparam int MAXP    = 8388607;
  localparam int MINP    = -8388608;
  localparam int MAX_GAP = 40;

  logic         clk_i;
  logic         rst_ni;
  logic [167:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;

  // Slot table as the predictor sees it
  bit                        table_valid [SLOTS];
  bit [nlsa_pkg::ID_W-1:0]   table_light [SLOTS];
  bit [nlsa_pkg::DIST_W-1:0] table_dist  [SLOTS];

  nlsa_pkg::out_item_t pending_grants[$];
  int                  mismatches;
  int                  send_idle_pct;
  int                  stall_pct;
  int                  hold_left;

  nearest_light_slot_allocator_unit #(
    .SLOT_COUNT   (SLOTS),
    .LIGHT_ID_BITS(ID_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Exact squared light-to-camera distance, unsigned Q34.16
  function automatic bit [nlsa_pkg::DIST_W-1:0] squared_range(nlsa_pkg::in_item_t req);
    longint dx, dy, dz, sum;
    dx  = longint'($signed(req.light_x)) - longint'($signed(req.camera_x));
    dy  = longint'($signed(req.light_y)) - longint'($signed(req.camera_y));
    dz  = longint'($signed(req.light_z)) - longint'($signed(req.camera_z));
    sum = dx * dx + dy * dy + dz * dz;
    return sum[nlsa_pkg::DIST_W-1:0];
  endfunction

  // Expected result of one request; updates the predicted slot table
  function automatic nlsa_pkg::out_item_t predict_slot_grant(logic mode,
                                                             nlsa_pkg::in_item_t req);
    nlsa_pkg::out_item_t       res;
    bit [nlsa_pkg::DIST_W-1:0] req_dist;
    int                        pick;
    int                        slot;
    res  = '0;
    slot = req.target_slot;
    if (mode == nlsa_pkg::MODE_REFRESH) begin
      res.granted_slot = req.target_slot;
      if (slot < SLOTS && table_valid[slot]) begin
        if (!req.light_alive) begin
          table_valid[slot] = 1'b0;
          res.evicted_valid = 1'b1;
          res.evicted_id    = table_light[slot];
        end else begin
          table_dist[slot] = squared_range(req);
        end
      end
    end else if (!req.already_mapped) begin
      req_dist = squared_range(req);
      pick     = 0;
      // first empty slot, else first farthest
      for (int i = 0; i < SLOTS; i++) begin
        if (!table_valid[i]) begin
          pick = i;
          break;
        end
        if (table_dist[i] > table_dist[pick]) pick = i;
      end
      if (!table_valid[pick] || table_dist[pick] > req_dist) begin
        if (table_valid[pick]) begin
          res.evicted_valid = 1'b1;
          res.evicted_id    = table_light[pick];
        end
        table_valid[pick] = 1'b1;
        table_light[pick] = req.light_id;
        table_dist[pick]  = req_dist;
        res.assigned      = 1'b1;
        res.granted_slot  = nlsa_pkg::SLOT_W'(pick);
      end
    end
    return res;
  endfunction

  function automatic nlsa_pkg::in_item_t at_range(logic [nlsa_pkg::ID_W-1:0] id,
                                                  int lx, int ly, int lz,
                                                  int cx, int cy, int cz);
    nlsa_pkg::in_item_t req;
    req          = '0;
    req.light_id = id;
    req.light_x  = nlsa_pkg::POS_W'(lx);
    req.light_y  = nlsa_pkg::POS_W'(ly);
    req.light_z  = nlsa_pkg::POS_W'(lz);
    req.camera_x = nlsa_pkg::POS_W'(cx);
    req.camera_y = nlsa_pkg::POS_W'(cy);
    req.camera_z = nlsa_pkg::POS_W'(cz);
    return req;
  endfunction

  // Coordinate at one of several scales; tiny scales give many distance ties
  function automatic logic signed [nlsa_pkg::POS_W-1:0] rand_coord(int scale);
    int v;
    case (scale)
      0: v = int'($urandom_range(6)) - 3;
      1: v = int'($urandom_range(2000)) - 1000;
      2: v = int'($urandom_range(32'hFFFFFF)) + MINP;
      default: v = $urandom_range(1) ? MAXP : MINP;
    endcase
    return nlsa_pkg::POS_W'(v);
  endfunction

  function automatic nlsa_pkg::in_item_t random_request();
    nlsa_pkg::in_item_t req;
    int                 scale;
    scale              = $urandom_range(3);
    req                = '0;
    req.target_slot    = nlsa_pkg::SLOT_W'($urandom_range(SLOTS - 1));
    req.light_id       = nlsa_pkg::ID_W'($urandom);
    req.already_mapped = ($urandom_range(9) == 0);
    req.light_alive    = ($urandom_range(9) < 7);
    req.light_x        = rand_coord(scale);
    req.light_y        = rand_coord(scale);
    req.light_z        = rand_coord(scale);
    req.camera_x       = rand_coord(scale);
    req.camera_y       = rand_coord(scale);
    req.camera_z       = rand_coord(scale);
    return req;
  endfunction

  function automatic logic random_mode();
    return ($urandom_range(9) < 7) ? nlsa_pkg::MODE_ADD : nlsa_pkg::MODE_REFRESH;
  endfunction

  // Offer one item after an optional idle gap and wait for the handshake
  task automatic issue_request(logic mode, nlsa_pkg::in_item_t req);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tdata  <= req;
    s_axis_tuser  <= mode;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    pending_grants = {pending_grants, predict_slot_grant(mode, req)};
  endtask

  // Fill all slots, extreme ids and distances, a tie for the farthest
  task automatic test_fill_table();
    issue_request(nlsa_pkg::MODE_ADD, at_range(16'h0000, 0, 0, 0, 0, 0, 0));
    issue_request(nlsa_pkg::MODE_ADD,
                  at_range(16'hFFFF, MAXP, MAXP, MAXP, MINP, MINP, MINP));
    issue_request(nlsa_pkg::MODE_ADD,
                  at_range(16'h1234, MINP, MINP, MINP, MAXP, MAXP, MAXP));
    for (int i = 3; i < SLOTS; i++)
      issue_request(nlsa_pkg::MODE_ADD,
                    at_range(nlsa_pkg::ID_W'(16'h0100 + i), 100 * i, -50, 7, 0, 0, 0));
  endtask

  task automatic test_already_mapped();
    nlsa_pkg::in_item_t req;
    req                = at_range(16'hABCD, 1, 2, 3, MAXP, MINP, 0);
    req.already_mapped = 1'b1;
    req.light_alive    = 1'b1;
    req.target_slot    = 3'd7;
    issue_request(nlsa_pkg::MODE_ADD, req);
  endtask

  // Same distance as the farthest slot: not strictly farther, so no grant
  task automatic test_add_rejected();
    issue_request(nlsa_pkg::MODE_ADD,
                  at_range(16'h5555, MAXP, MAXP, MAXP, MINP, MINP, MINP));
  endtask

  // Near lights push out the two tied farthest ones, first one first
  task automatic test_eviction();
    issue_request(nlsa_pkg::MODE_ADD, at_range(16'h7001, 1, 1, 1, 0, 0, 0));
    issue_request(nlsa_pkg::MODE_ADD, at_range(16'h7002, -1, 0, 2, 0, 0, 0));
  endtask

  task automatic test_refresh();
    nlsa_pkg::in_item_t req;
    // live light moved far away, then loses its slot to a near add
    req             = at_range(16'h0000, MAXP, MINP, MAXP, MINP, MAXP, MINP);
    req.target_slot = 3'd3;
    req.light_alive = 1'b1;
    issue_request(nlsa_pkg::MODE_REFRESH, req);
    issue_request(nlsa_pkg::MODE_ADD, at_range(16'h8001, 0, 0, 5, 0, 0, 0));
    // dead light frees its slot; refreshes of the empty slot do nothing
    req             = at_range(16'hFFFF, 5, 5, 5, 0, 0, 0);
    req.target_slot = 3'd0;
    req.light_alive = 1'b0;
    issue_request(nlsa_pkg::MODE_REFRESH, req);
    issue_request(nlsa_pkg::MODE_REFRESH, req);
    req.light_alive = 1'b1;
    issue_request(nlsa_pkg::MODE_REFRESH, req);
    // freed slot is reused
    issue_request(nlsa_pkg::MODE_ADD, at_range(16'h8002, 9, 9, 9, 0, 0, 0));
    req             = at_range(16'h0000, 0, 0, 0, 0, 0, 0);
    req.target_slot = 3'd7;
    req.light_alive = 1'b0;
    issue_request(nlsa_pkg::MODE_REFRESH, req);
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk_i);
    hold_left = 300;
    repeat (30) issue_request(random_mode(), random_request());
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) issue_request(random_mode(), random_request());
  endtask

  // Receiver ready, with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    nlsa_pkg::out_item_t got;
    nlsa_pkg::out_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = nlsa_pkg::out_item_t'(m_axis_tdata);
      if (pending_grants.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result assigned=%0d slot=%0d ev=%0d id=%h", $time,
                 got.assigned, got.granted_slot, got.evicted_valid, got.evicted_id);
      end else begin
        want = pending_grants.pop_front();
        if (got.assigned !== want.assigned || got.granted_slot !== want.granted_slot ||
            got.evicted_valid !== want.evicted_valid || got.evicted_id !== want.evicted_id)
        begin
          mismatches++;
          $display("%0t: mismatch expected assigned=%0d slot=%0d ev=%0d id=%h", $time,
                   want.assigned, want.granted_slot, want.evicted_valid, want.evicted_id);
          $display("%0t:          actual   assigned=%0d slot=%0d ev=%0d id=%h", $time,
                   got.assigned, got.granted_slot, got.evicted_valid, got.evicted_id);
        end
      end
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("[nearest_light_slot_allocator_unit] ERROR");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = nlsa_pkg::MODE_ADD;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_table();
    test_already_mapped();
    test_add_rejected();
    test_eviction();
    test_refresh();
    test_backpressure();
    test_random_traffic(200, 0, 0);
    test_random_traffic(200, 75, 0);
    test_random_traffic(200, 0, 75);
    test_random_traffic(200, 9, 9);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("[nearest_light_slot_allocator_unit] OK");
    else
      $display("[nearest_light_slot_allocator_unit] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
hdl/nlsa_pkg.sv
hdl/nlsa_dist.sv
hdl/nearest_light_slot_allocator_unit.sv
sim/tb_top.sv
